// ----- rtl/pad_source_index_mapper_assert.svh -----
// assertion macros for the pad source index mapper
`ifndef PAD_SOURCE_INDEX_MAPPER_ASSERT_SVH
`define PAD_SOURCE_INDEX_MAPPER_ASSERT_SVH

// implication checked on every clock out of reset
`define PSIM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// invariant checked on every clock out of reset
`define PSIM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ----- rtl/psim_pkg.sv -----
// shared types and constants of the pad source index mapper
`default_nettype none
package psim_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STAGES = 7;
  localparam int LATENCY = 12;

  localparam logic [1:0] MODE_CONSTANT = 2'd0;
  localparam logic [1:0] MODE_REFLECT  = 2'd1;
  localparam logic [1:0] MODE_EDGE     = 2'd2;
  localparam logic [1:0] MODE_WRAP     = 2'd3;

  localparam logic [2:0] REG_PAD_MODE   = 3'd0;
  localparam logic [2:0] REG_INPUT_ROWS = 3'd1;
  localparam logic [2:0] REG_INPUT_COLS = 3'd2;
  localparam logic [2:0] REG_PAD_TOP    = 3'd3;
  localparam logic [2:0] REG_PAD_BOTTOM = 3'd4;
  localparam logic [2:0] REG_PAD_LEFT   = 3'd5;
  localparam logic [2:0] REG_PAD_RIGHT  = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_BAD_CFG = 2'd2;

  typedef struct packed {
    logic [11:0] coord;
    logic        pad;
    logic        outside;
    logic        bad;
  } axis_res_t;

  typedef struct packed {
    logic [13:0] rem;
    logic [13:0] dvd;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t s, logic [12:0] dv);
    div_state_t  o;
    logic [13:0] t;
    o = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {o.rem[12:0], o.dvd[13]};
      o.dvd = {o.dvd[12:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        o.rem = t - {1'b0, dv};
      end else begin
        o.rem = t;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/psim_axis.sv -----
// one axis: pad plan, pipelined remainder and coordinate mapping
`default_nettype none
module psim_axis (
  input  wire logic                clk,
  input  wire logic [1:0]          mode,
  input  wire logic [12:0]         dim,
  input  wire logic [13:0]         pad_head,
  input  wire logic [13:0]         pad_end,
  input  wire logic [13:0]         pos,
  output psim_pkg::axis_res_t      res
);

  localparam int DIV_N = psim_pkg::DIV_STAGES;

  // plan, refreshed every cycle from the registers
  logic signed [15:0] dim_s, pb_s, pe_s, cb, ce, posb, pose, od;
  logic signed [15:0] kept_s;
  logic               over, bad_w;
  logic [12:0]        lead_r, crop_r, kept_r, per_r;
  logic signed [15:0] odim_r;
  logic               bad_r;

  always_comb begin
    dim_s  = $signed({3'b0, dim});
    pb_s   = $signed({{2{pad_head[13]}}, pad_head});
    pe_s   = $signed({{2{pad_end[13]}}, pad_end});
    cb     = pb_s < 0 ? -pb_s : 16'sd0;
    ce     = pe_s < 0 ? -pe_s : 16'sd0;
    posb   = pb_s > 0 ? pb_s : 16'sd0;
    pose   = pe_s > 0 ? pe_s : 16'sd0;
    od     = dim_s + pb_s + pe_s;
    over   = (cb > dim_s) || (ce > dim_s - cb);
    kept_s = over ? 16'sd0 : dim_s - cb - ce;
    bad_w  = (od < 0) || (32'(dim) > psim_pkg::MAX_DIM);
    if (mode != psim_pkg::MODE_CONSTANT) begin
      if (over || (kept_s == 0 && od != 0)) begin
        bad_w = 1'b1;
      end
    end
    if (mode == psim_pkg::MODE_REFLECT && (posb != 0 || pose != 0)) begin
      if (!(kept_s >= 2 && posb < kept_s && pose < kept_s)) begin
        bad_w = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    lead_r <= posb[12:0];
    crop_r <= cb[12:0];
    kept_r <= kept_s[12:0];
    per_r  <= (kept_s == 0) ? 13'd0 : 13'({kept_s[11:0] - 12'd1, 1'b0});
    odim_r <= od;
    bad_r  <= bad_w;
  end

  // stage 1: coordinate capture
  logic [13:0] pos1_r;
  always_ff @(posedge clk) begin
    pos1_r <= pos;
  end

  // stage 2: offset into the kept span, magnitude and divisor
  logic signed [15:0] inside_w;
  logic [15:0]        mag_w;
  logic signed [15:0] inside2_r;
  logic               neg2_r, outside2_r;
  logic [13:0]        mag2_r;
  logic [12:0]        div2_r;

  always_comb begin
    inside_w = $signed({2'b0, pos1_r}) - $signed({3'b0, lead_r});
    mag_w    = inside_w[15] ? 16'(-inside_w) : 16'(inside_w);
  end

  always_ff @(posedge clk) begin
    inside2_r  <= inside_w;
    neg2_r     <= inside_w[15];
    mag2_r     <= mag_w[13:0];
    outside2_r <= $signed({2'b0, pos1_r}) >= odim_r;
    div2_r     <= (mode == psim_pkg::MODE_REFLECT) ? per_r : kept_r;
  end

  // remainder pipeline
  psim_pkg::div_state_t ds_r  [DIV_N];
  logic signed [15:0]   din_r [DIV_N];
  logic                 dneg_r[DIV_N];
  logic                 dout_r[DIV_N];
  logic [12:0]          ddv_r [DIV_N];

  always_ff @(posedge clk) begin
    ds_r[0]   <= psim_pkg::div_step('{rem: 14'd0, dvd: mag2_r}, div2_r);
    din_r[0]  <= inside2_r;
    dneg_r[0] <= neg2_r;
    dout_r[0] <= outside2_r;
    ddv_r[0]  <= div2_r;
    for (int k = 1; k < DIV_N; k++) begin
      ds_r[k]   <= psim_pkg::div_step(ds_r[k-1], ddv_r[k-1]);
      din_r[k]  <= din_r[k-1];
      dneg_r[k] <= dneg_r[k-1];
      dout_r[k] <= dout_r[k-1];
      ddv_r[k]  <= ddv_r[k-1];
    end
  end

  // mapping stage
  logic [12:0]        r_w, m_w;
  logic signed [15:0] in_w;
  logic signed [15:0] kept_sw;
  logic [13:0]        coord_w;
  logic               pad_w;
  psim_pkg::axis_res_t res_r;

  always_comb begin
    in_w    = din_r[DIV_N-1];
    kept_sw = $signed({3'b0, kept_r});
    r_w     = ds_r[DIV_N-1].rem[12:0];
    if (dneg_r[DIV_N-1] && r_w != 13'd0) begin
      r_w = ddv_r[DIV_N-1] - r_w;
    end
    m_w     = (r_w >= kept_r) ? per_r - r_w : r_w;
    pad_w   = 1'b0;
    coord_w = 14'(crop_r);
    case (mode)
      psim_pkg::MODE_CONSTANT: begin
        pad_w   = (in_w < 0) || (in_w >= kept_sw);
        coord_w = 14'(crop_r) + in_w[13:0];
      end
      psim_pkg::MODE_WRAP: begin
        pad_w   = (kept_r == 13'd0);
        coord_w = 14'(crop_r) + 14'(r_w);
      end
      psim_pkg::MODE_EDGE: begin
        pad_w = (kept_r == 13'd0);
        if (in_w < 0) begin
          coord_w = 14'(crop_r);
        end else if (in_w >= kept_sw) begin
          coord_w = 14'(crop_r) + 14'(kept_r) - 14'd1;
        end else begin
          coord_w = 14'(crop_r) + in_w[13:0];
        end
      end
      psim_pkg::MODE_REFLECT: begin
        pad_w = (kept_r == 13'd0);
        if (kept_r == 13'd1) begin
          coord_w = 14'(crop_r);
        end else begin
          coord_w = 14'(crop_r) + 14'(m_w);
        end
      end
      default: begin
        pad_w = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r.coord   <= coord_w[11:0];
    res_r.pad     <= pad_w;
    res_r.outside <= dout_r[DIV_N-1];
    res_r.bad     <= bad_r;
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ----- rtl/pad_source_index_mapper.sv -----
// top level of the pad source index mapper
//
//   port group  dir  beat marked by
//   in_*        in   start high with busy low
//   out_*       out  out_valid, one cycle, no back pressure
//   cfg_*       in   cfg_we
//
// one beat enters per cycle; its result passes the capture, offset, remainder, mapping, product and output registers
// the seven-stage remainder pipeline of each axis makes up most of that path
// busy stays low, the pipeline always advances
// reset clears the config registers and the valid bits, in-flight beats are dropped
`default_nettype none
module pad_source_index_mapper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [13:0] in_out_row,
  input  wire logic [13:0] in_out_col,
  output      logic        out_valid,
  output      logic [11:0] out_src_row,
  output      logic [11:0] out_src_col,
  output      logic [23:0] out_source_index,
  output      logic        out_is_pad,
  output      logic [1:0]  out_status,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  localparam int LAT = psim_pkg::LATENCY;

  logic [1:0]  pad_mode_r;
  logic [12:0] input_rows_r, input_cols_r;
  logic [13:0] pad_top_r, pad_bottom_r, pad_left_r, pad_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_mode_r   <= '0;
      input_rows_r <= '0;
      input_cols_r <= '0;
      pad_top_r    <= '0;
      pad_bottom_r <= '0;
      pad_left_r   <= '0;
      pad_right_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        psim_pkg::REG_PAD_MODE:   pad_mode_r   <= cfg_data[1:0];
        psim_pkg::REG_INPUT_ROWS: input_rows_r <= cfg_data[12:0];
        psim_pkg::REG_INPUT_COLS: input_cols_r <= cfg_data[12:0];
        psim_pkg::REG_PAD_TOP:    pad_top_r    <= cfg_data;
        psim_pkg::REG_PAD_BOTTOM: pad_bottom_r <= cfg_data;
        psim_pkg::REG_PAD_LEFT:   pad_left_r   <= cfg_data;
        psim_pkg::REG_PAD_RIGHT:  pad_right_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign busy = 1'b0;

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  psim_pkg::axis_res_t row_res, col_res;

  psim_axis u_row (
    .clk       (clk),
    .mode      (pad_mode_r),
    .dim       (input_rows_r),
    .pad_head  (pad_top_r),
    .pad_end   (pad_bottom_r),
    .pos       (in_out_row),
    .res       (row_res)
  );

  psim_axis u_col (
    .clk       (clk),
    .mode      (pad_mode_r),
    .dim       (input_cols_r),
    .pad_head  (pad_left_r),
    .pad_end   (pad_right_r),
    .pos       (in_out_col),
    .res       (col_res)
  );

  // product stage
  logic [24:0] prod_r;
  logic [11:0] srow_r, scol_r;
  logic [1:0]  st_r;
  logic        pad_r;
  logic [1:0]  st_w;

  always_comb begin
    if (row_res.bad || col_res.bad) begin
      st_w = psim_pkg::ST_BAD_CFG;
    end else if (row_res.outside || col_res.outside) begin
      st_w = psim_pkg::ST_OUTSIDE;
    end else begin
      st_w = psim_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= row_res.coord * input_cols_r;
    srow_r <= row_res.coord;
    scol_r <= col_res.coord;
    st_r   <= st_w;
    pad_r  <= row_res.pad || col_res.pad;
  end

  // output stage
  logic [23:0] idx_r;
  logic [11:0] orow_r, ocol_r;
  logic        opad_r;
  logic [1:0]  ost_r;
  logic [24:0] sum_w;
  logic        use_w;

  always_comb begin
    sum_w = prod_r + 25'(scol_r);
    use_w = (st_r == psim_pkg::ST_OK) && !pad_r;
  end

  always_ff @(posedge clk) begin
    idx_r  <= use_w ? sum_w[23:0] : 24'd0;
    orow_r <= use_w ? srow_r : 12'd0;
    ocol_r <= use_w ? scol_r : 12'd0;
    opad_r <= (st_r == psim_pkg::ST_OK) && pad_r;
    ost_r  <= st_r;
  end

  assign out_valid        = vld_r[LAT-1];
  assign out_src_row      = orow_r;
  assign out_src_col      = ocol_r;
  assign out_source_index = idx_r;
  assign out_is_pad       = opad_r;
  assign out_status       = ost_r;

endmodule
`default_nettype wire

// ----- rtl/psim_checker.sv -----
// port-level checks of the pad source index mapper and their binding
`default_nettype none
`include "pad_source_index_mapper_assert.svh"
module psim_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [11:0] out_src_row,
  input wire logic [11:0] out_src_col,
  input wire logic [23:0] out_source_index,
  input wire logic        out_is_pad,
  input wire logic [1:0]  out_status
);

  `PSIM_ASSERT_IMP(a_beat_latency, out_valid, $past(start && !busy, psim_pkg::LATENCY), "result beat without a matching input beat")
  `PSIM_ASSERT_IMP(a_status_clears, out_valid && out_status != psim_pkg::ST_OK, out_src_row == 12'd0 && out_src_col == 12'd0 && out_source_index == 24'd0 && !out_is_pad, "fields not cleared on error status")
  `PSIM_ASSERT_IMP(a_pad_clears, out_valid && out_is_pad, out_src_row == 12'd0 && out_src_col == 12'd0 && out_source_index == 24'd0, "fields not cleared on pad")
  `PSIM_ASSERT_IMP(a_status_code, out_valid, out_status == psim_pkg::ST_OK || out_status == psim_pkg::ST_OUTSIDE || out_status == psim_pkg::ST_BAD_CFG, "unknown status code")
  `PSIM_ASSERT_ALWAYS(a_no_busy, !busy, "busy raised")

endmodule

bind pad_source_index_mapper psim_checker u_psim_checker (.*);
`default_nettype wire
